// ----- src/aabb_building_collision_scan_macros.svh -----
// assertion macros used by the collision scan top level
`ifndef AABB_BUILDING_COLLISION_SCAN_MACROS_SVH
`define AABB_BUILDING_COLLISION_SCAN_MACROS_SVH

// checked only while out of reset
`define AABB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// checked at every edge, reset included
`define AABB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

// ----- src/aabb_scan_pkg.sv -----
// types, constants and sizes for the building footprint collision scan
package aabb_scan_pkg;

    // table and tile geometry
    localparam int ENTRY_COUNT = 64;
    localparam int TILE_SCALE  = 32;

    // fixed field widths
    localparam int OP_W    = 1;
    localparam int EIDX_W  = 6;
    localparam int TILE_W  = 9;
    localparam int WID_W   = 5;
    localparam int QRY_W   = 17;
    localparam int SKIP_W  = 7;
    localparam int HIT_W   = 6;

    // derived widths
    localparam int IDX_W    = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int CNT_W    = $clog2(ENTRY_COUNT + 1);
    localparam int SCALE_W  = $clog2(TILE_SCALE + 1);
    localparam int COORD_W  = TILE_W + SCALE_W + 2;
    localparam int CMP_W    = ((COORD_W > QRY_W) ? COORD_W : QRY_W) + 1;
    localparam int SIDX_W   = (IDX_W > SKIP_W - 1) ? IDX_W : SKIP_W - 1;

    // item codes
    localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
    localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

    // one stored footprint
    typedef struct packed {
        logic [TILE_W-1:0] tile_x;
        logic [TILE_W-1:0] tile_y;
        logic [WID_W-1:0]  width_x;
        logic [WID_W-1:0]  width_y;
    } entry_t;

    // footprint box in fine units, with its scan position
    typedef struct packed {
        logic                      vld;
        logic                      on;
        logic [IDX_W-1:0]          idx;
        logic signed [COORD_W-1:0] lo_x;
        logic signed [COORD_W-1:0] hi_x;
        logic signed [COORD_W-1:0] lo_y;
        logic signed [COORD_W-1:0] hi_y;
    } box_t;

endpackage

// ----- src/aabb_scan_box.sv -----
// box stage: turns a stored footprint into its inclusive fine-unit box
module aabb_scan_box (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_vld,
    input  logic                  in_on,
    input  logic [aabb_scan_pkg::IDX_W-1:0] in_idx,
    input  aabb_scan_pkg::entry_t in_entry,
    input  logic                  flush,
    output aabb_scan_pkg::box_t   box
);
    import aabb_scan_pkg::*;

    logic                      vld_reg;
    logic                      on_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic signed [COORD_W-1:0] lo_x_reg, hi_x_reg, lo_y_reg, hi_y_reg;

    logic signed [TILE_W:0]    org_x, org_y;
    logic signed [COORD_W-1:0] lo_x_next, hi_x_next, lo_y_next, hi_y_next;
    logic signed [COORD_W-1:0] span_x, span_y;

    // minimum tile is centre minus half width, rounded down
    always_comb begin
        org_x     = signed'({1'b0, in_entry.tile_x})
                  - signed'((TILE_W+1)'(in_entry.width_x >> 1));
        org_y     = signed'({1'b0, in_entry.tile_y})
                  - signed'((TILE_W+1)'(in_entry.width_y >> 1));
        lo_x_next = COORD_W'(org_x) * COORD_W'(TILE_SCALE);
        lo_y_next = COORD_W'(org_y) * COORD_W'(TILE_SCALE);
        span_x    = signed'(COORD_W'(in_entry.width_x)) * COORD_W'(TILE_SCALE);
        span_y    = signed'(COORD_W'(in_entry.width_y)) * COORD_W'(TILE_SCALE);
        hi_x_next = lo_x_next + span_x - COORD_W'(1);
        hi_y_next = lo_y_next + span_y - COORD_W'(1);
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= in_vld && !flush;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        on_reg   <= in_on;
        idx_reg  <= in_idx;
        lo_x_reg <= lo_x_next;
        hi_x_reg <= hi_x_next;
        lo_y_reg <= lo_y_next;
        hi_y_reg <= hi_y_next;
    end

    assign box.vld  = vld_reg;
    assign box.on   = on_reg;
    assign box.idx  = idx_reg;
    assign box.lo_x = lo_x_reg;
    assign box.hi_x = hi_x_reg;
    assign box.lo_y = lo_y_reg;
    assign box.hi_y = hi_y_reg;

endmodule

// ----- src/aabb_building_collision_scan.sv -----
// top level: footprint table memory, scan sequencer and result register
//
// Input channel s_*: one item per transfer. A write item (opcode 0) loads
// one table slot; a query item (opcode 1) scans the table for boxes that
// overlap the query box. Result channel m_*: exactly one transfer per item,
// in item order; a write item returns all zeros.
// A write item goes straight from idle to the result stage. A query reads
// one table entry per cycle from the footprint memory; the registered read,
// the box stage and the compare form a pipeline, and the scan stops at the
// first counted overlap or at the last entry. The result stage loads the
// output register once any earlier result has been taken, and the block
// then returns to idle.
// One item is worked on at a time; s_ready is high while the block is idle.
// The finished result sits in an output register, so the next item is
// taken while an earlier result still waits on m_ready; that next item
// then waits in its result stage, with s_ready low, until the stall ends.
// Reset (synchronous, aresetn low) clears every valid flag, so the table
// reads as empty; the footprint fields themselves are not cleared.
module aabb_building_collision_scan (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [aabb_scan_pkg::OP_W-1:0]       s_opcode,
    input  logic [aabb_scan_pkg::EIDX_W-1:0]     s_entry_index,
    input  logic                                 s_entry_on,
    input  logic [aabb_scan_pkg::TILE_W-1:0]     s_tile_x,
    input  logic [aabb_scan_pkg::TILE_W-1:0]     s_tile_y,
    input  logic [aabb_scan_pkg::WID_W-1:0]      s_width_x,
    input  logic [aabb_scan_pkg::WID_W-1:0]      s_width_y,
    input  logic signed [aabb_scan_pkg::QRY_W-1:0]  s_query_min_x,
    input  logic signed [aabb_scan_pkg::QRY_W-1:0]  s_query_min_z,
    input  logic signed [aabb_scan_pkg::QRY_W-1:0]  s_query_max_x,
    input  logic signed [aabb_scan_pkg::QRY_W-1:0]  s_query_max_z,
    input  logic signed [aabb_scan_pkg::SKIP_W-1:0] s_ignore_index,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_hit,
    output logic [aabb_scan_pkg::HIT_W-1:0]      m_hit_index,
    output logic                                 m_ignored_seen
);
    import aabb_scan_pkg::*;

    `include "aabb_building_collision_scan_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_PUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // footprint memory and valid flags
    entry_t           mem [ENTRY_COUNT];
    logic [ENTRY_COUNT-1:0] valid_reg;
    entry_t           rd_data_reg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    entry_t           wr_data;

    // scan control
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             p1_vld_reg, p1_vld_next;
    logic             p1_on_reg;
    logic [IDX_W-1:0] p1_idx_reg;
    box_t             box;

    // query held for the scan
    logic signed [QRY_W-1:0]  q_min_x_reg, q_min_z_reg, q_max_x_reg, q_max_z_reg;
    logic signed [SKIP_W-1:0] q_skip_reg;

    // result being built, and the output register
    logic             res_hit_reg, res_hit_next;
    logic [HIT_W-1:0] res_idx_reg, res_idx_next;
    logic             res_seen_reg, res_seen_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_hit_reg, m_hit_next;
    logic [HIT_W-1:0] m_hit_index_reg, m_hit_index_next;
    logic             m_seen_reg, m_seen_next;

    logic s_xfer;
    logic ovl, ovl_skip, ovl_hit, is_skip, is_last, scan_done;

    assign s_ready = (state_reg == S_IDLE);
    assign s_xfer  = s_valid && s_ready;

    // table write from a write item; slots beyond the table are dropped
    assign wr_en   = s_xfer && (s_opcode == OP_WRITE)
                  && (32'(s_entry_index) < ENTRY_COUNT);
    assign wr_addr = IDX_W'(s_entry_index);
    assign rd_addr = rd_cnt_reg[IDX_W-1:0];
    always_comb begin
        wr_data.tile_x  = s_tile_x;
        wr_data.tile_y  = s_tile_y;
        wr_data.width_x = s_width_x;
        wr_data.width_y = s_width_y;
    end

    // footprint memory, one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // valid flags, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= s_entry_on;
        end
    end

    // box stage
    aabb_scan_box u_box (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_vld   (p1_vld_reg),
        .in_on    (p1_on_reg),
        .in_idx   (p1_idx_reg),
        .in_entry (rd_data_reg),
        .flush    (scan_done),
        .box      (box)
    );

    // overlap compare on both axes
    always_comb begin
        ovl = box.vld && box.on
           && (CMP_W'(q_max_x_reg) >= CMP_W'(box.lo_x))
           && (CMP_W'(q_min_x_reg) <= CMP_W'(box.hi_x))
           && (CMP_W'(q_max_z_reg) >= CMP_W'(box.lo_y))
           && (CMP_W'(q_min_z_reg) <= CMP_W'(box.hi_y));
        is_skip   = !q_skip_reg[SKIP_W-1]
                 && (SIDX_W'(box.idx) == SIDX_W'(q_skip_reg[SKIP_W-2:0]));
        is_last   = (box.idx == IDX_W'(ENTRY_COUNT - 1));
        ovl_skip  = ovl && is_skip;
        ovl_hit   = ovl && !is_skip;
        scan_done = box.vld && (ovl_hit || is_last);
    end

    // sequencer and result path
    always_comb begin
        state_next       = state_reg;
        rd_cnt_next      = rd_cnt_reg;
        p1_vld_next      = 1'b0;
        res_hit_next     = res_hit_reg;
        res_idx_next     = res_idx_reg;
        res_seen_next    = res_seen_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_hit_next       = m_hit_reg;
        m_hit_index_next = m_hit_index_reg;
        m_seen_next      = m_seen_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_hit_next  = 1'b0;
                    res_idx_next  = '0;
                    res_seen_next = 1'b0;
                    rd_cnt_next   = '0;
                    if (s_opcode == OP_QUERY) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_PUT;
                    end
                end
            end
            S_SCAN: begin
                if ((rd_cnt_reg < CNT_W'(ENTRY_COUNT)) && !scan_done) begin
                    p1_vld_next = 1'b1;
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                if (ovl_skip) begin
                    res_seen_next = 1'b1;
                end
                if (ovl_hit) begin
                    res_hit_next = 1'b1;
                    res_idx_next = HIT_W'(box.idx);
                end
                if (scan_done) begin
                    state_next = S_PUT;
                end
            end
            S_PUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_hit_next       = res_hit_reg;
                    m_hit_index_next = res_idx_reg;
                    m_seen_next      = res_seen_reg;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rd_cnt_reg  <= '0;
            p1_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_cnt_reg  <= rd_cnt_next;
            p1_vld_reg  <= p1_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        p1_on_reg       <= valid_reg[rd_addr];
        p1_idx_reg      <= rd_addr;
        res_hit_reg     <= res_hit_next;
        res_idx_reg     <= res_idx_next;
        res_seen_reg    <= res_seen_next;
        m_hit_reg       <= m_hit_next;
        m_hit_index_reg <= m_hit_index_next;
        m_seen_reg      <= m_seen_next;
        if (s_xfer) begin
            q_min_x_reg <= s_query_min_x;
            q_min_z_reg <= s_query_min_z;
            q_max_x_reg <= s_query_max_x;
            q_max_z_reg <= s_query_max_z;
            q_skip_reg  <= s_ignore_index;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_hit_index    = m_hit_index_reg;
    assign m_ignored_seen = m_seen_reg;

    // a write item goes straight to the result stage
    `AABB_ASSERT(a_write_to_put, s_xfer && (s_opcode == OP_WRITE) |=> state_reg == S_PUT, "write item did not go to result stage")
    // the read pipeline is empty outside a scan
    `AABB_ASSERT(a_pipe_flushed, state_reg != S_SCAN |-> !p1_vld_reg && !box.vld, "scan pipeline not flushed")
    // the read counter never runs past the table
    `AABB_ASSERT(a_cnt_bound, rd_cnt_reg <= CNT_W'(ENTRY_COUNT), "read counter beyond table")
    // a result without a hit carries index zero
    `AABB_ASSERT(a_no_hit_zero, m_valid && !m_hit |-> m_hit_index == '0, "index set without hit")
    // reset leaves the block idle with no result pending
    `AABB_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (state_reg == S_IDLE) && !m_valid_reg, "block not idle after reset")

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for the building footprint collision scan
module testbench;
    import aabb_scan_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 2 * ENTRY_COUNT + 16;
    localparam int RANDOM_ITEMS = 480;
    localparam int NO_IGNORE    = -1;
    localparam int Q_LOWEST     = -65536;
    localparam int Q_HIGHEST    = 65535;

    // one input transfer, every field present whatever the opcode
    typedef struct {
        logic [OP_W-1:0]          opcode;
        logic [EIDX_W-1:0]        entry_index;
        logic                     entry_on;
        logic [TILE_W-1:0]        tile_x;
        logic [TILE_W-1:0]        tile_y;
        logic [WID_W-1:0]         width_x;
        logic [WID_W-1:0]         width_y;
        logic signed [QRY_W-1:0]  query_min_x;
        logic signed [QRY_W-1:0]  query_min_z;
        logic signed [QRY_W-1:0]  query_max_x;
        logic signed [QRY_W-1:0]  query_max_z;
        logic signed [SKIP_W-1:0] ignore_index;
    } scan_item_t;

    typedef struct packed {
        logic             hit;
        logic [HIT_W-1:0] hit_index;
        logic             ignored_seen;
    } scan_result_t;

    typedef struct {
        scan_item_t   item;
        bit           known;
        scan_result_t result;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [OP_W-1:0]          s_opcode;
    logic [EIDX_W-1:0]        s_entry_index;
    logic                     s_entry_on;
    logic [TILE_W-1:0]        s_tile_x;
    logic [TILE_W-1:0]        s_tile_y;
    logic [WID_W-1:0]         s_width_x;
    logic [WID_W-1:0]         s_width_y;
    logic signed [QRY_W-1:0]  s_query_min_x;
    logic signed [QRY_W-1:0]  s_query_min_z;
    logic signed [QRY_W-1:0]  s_query_max_x;
    logic signed [QRY_W-1:0]  s_query_max_z;
    logic signed [SKIP_W-1:0] s_ignore_index;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_hit;
    logic [HIT_W-1:0]         m_hit_index;
    logic                     m_ignored_seen;

    // local copy of the footprint table
    logic              fp_on      [ENTRY_COUNT];
    logic [TILE_W-1:0] fp_tile_x  [ENTRY_COUNT];
    logic [TILE_W-1:0] fp_tile_y  [ENTRY_COUNT];
    logic [WID_W-1:0]  fp_width_x [ENTRY_COUNT];
    logic [WID_W-1:0]  fp_width_y [ENTRY_COUNT];

    scan_result_t pending_results[$];
    stim_row_t    directed_rows[$];
    int           mismatches = 0;
    bit           steady_sender = 1'b0;
    bit           steady_receiver = 1'b0;

    always #HALF_PERIOD aclk = ~aclk;

    aabb_building_collision_scan u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_entry_index  (s_entry_index),
        .s_entry_on     (s_entry_on),
        .s_tile_x       (s_tile_x),
        .s_tile_y       (s_tile_y),
        .s_width_x      (s_width_x),
        .s_width_y      (s_width_y),
        .s_query_min_x  (s_query_min_x),
        .s_query_min_z  (s_query_min_z),
        .s_query_max_x  (s_query_max_x),
        .s_query_max_z  (s_query_max_z),
        .s_ignore_index (s_ignore_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_hit_index    (m_hit_index),
        .m_ignored_seen (m_ignored_seen)
    );

    // inclusive fine-unit span of one footprint axis
    function automatic void footprint_span(input logic [TILE_W-1:0] tile,
                                           input logic [WID_W-1:0] w,
                                           output int lo, output int hi);
        lo = (int'(tile) - int'(w) / 2) * TILE_SCALE;
        hi = lo + int'(w) * TILE_SCALE - 1;
    endfunction

    function automatic bit axis_overlaps(int qlo, int qhi, logic [TILE_W-1:0] tile,
                                         logic [WID_W-1:0] w);
        int lo, hi;
        footprint_span(tile, w, lo, hi);
        return qhi >= lo && qlo <= hi;
    endfunction

    // applies a write to the table, or scans it for a query
    function automatic scan_result_t scan_footprints(scan_item_t it);
        scan_result_t r;
        int skip;
        r = '0;
        if (it.opcode == OP_WRITE) begin
            fp_on[it.entry_index]      = it.entry_on;
            fp_tile_x[it.entry_index]  = it.tile_x;
            fp_tile_y[it.entry_index]  = it.tile_y;
            fp_width_x[it.entry_index] = it.width_x;
            fp_width_y[it.entry_index] = it.width_y;
            return r;
        end
        skip = int'(it.ignore_index);
        for (int k = 0; k < ENTRY_COUNT; k++) begin
            if (fp_on[k]
                && axis_overlaps(int'(it.query_min_x), int'(it.query_max_x),
                                 fp_tile_x[k], fp_width_x[k])
                && axis_overlaps(int'(it.query_min_z), int'(it.query_max_z),
                                 fp_tile_y[k], fp_width_y[k])) begin
                if (k == skip) begin
                    r.ignored_seen = 1'b1;
                end else begin
                    r.hit       = 1'b1;
                    r.hit_index = HIT_W'(k);
                    break;
                end
            end
        end
        return r;
    endfunction

    // every field random, so unused fields still toggle
    function automatic scan_item_t random_payload();
        scan_item_t it;
        it.opcode       = OP_W'($urandom);
        it.entry_index  = EIDX_W'($urandom);
        it.entry_on     = 1'($urandom);
        it.tile_x       = TILE_W'($urandom);
        it.tile_y       = TILE_W'($urandom);
        it.width_x      = WID_W'($urandom);
        it.width_y      = WID_W'($urandom);
        it.query_min_x  = QRY_W'($urandom);
        it.query_min_z  = QRY_W'($urandom);
        it.query_max_x  = QRY_W'($urandom);
        it.query_max_z  = QRY_W'($urandom);
        it.ignore_index = SKIP_W'($urandom);
        return it;
    endfunction

    function automatic scan_item_t write_item(int idx, bit on, int tx, int ty, int wx, int wy);
        scan_item_t it;
        it = random_payload();
        it.opcode      = OP_WRITE;
        it.entry_index = EIDX_W'(idx);
        it.entry_on    = on;
        it.tile_x      = TILE_W'(tx);
        it.tile_y      = TILE_W'(ty);
        it.width_x     = WID_W'(wx);
        it.width_y     = WID_W'(wy);
        return it;
    endfunction

    function automatic scan_item_t query_item(int minx, int minz, int maxx, int maxz, int ign);
        scan_item_t it;
        it = random_payload();
        it.opcode       = OP_QUERY;
        it.query_min_x  = QRY_W'(minx);
        it.query_min_z  = QRY_W'(minz);
        it.query_max_x  = QRY_W'(maxx);
        it.query_max_z  = QRY_W'(maxz);
        it.ignore_index = SKIP_W'(ign);
        return it;
    endfunction

    function automatic void add_row(scan_item_t it, bit known, bit hit = 1'b0,
                                    int idx = 0, bit seen = 1'b0);
        stim_row_t row;
        row.item   = it;
        row.known  = known;
        row.result = {hit, HIT_W'(idx), seen};
        directed_rows.push_back(row);
    endfunction

    // query range on one axis placed around a footprint span, edges often exact
    function automatic void aimed_range(int lo, int hi, output int qlo, output int qhi);
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 6) begin
            qlo = lo + $urandom_range(0, 2) - 1;
            qhi = hi + $urandom_range(0, 2) - 1;
            if (mode > 2) begin
                qlo = qlo + $urandom_range(0, 96) - 48;
                qhi = qhi + $urandom_range(0, 96) - 48;
            end
        end else if (mode < 8) begin
            // query abutting the top edge
            qlo = hi + $urandom_range(0, 2) - 1;
            qhi = qlo + $urandom_range(0, 64);
        end else begin
            // query abutting the bottom edge
            qhi = lo + $urandom_range(0, 2) - 1;
            qlo = qhi - $urandom_range(0, 64);
        end
    endfunction

    function automatic int pick_width();
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, 31);
        return $urandom_range(1, 16);
    endfunction

    function automatic scan_item_t random_item();
        scan_item_t it;
        int pick, k, tx, ty, lo_x, hi_x, lo_z, hi_z, qx0, qx1, qz0, qz1, ign;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            // table write, often packed into one corner so boxes overlap
            if ($urandom_range(0, 1)) begin
                tx = $urandom_range(0, 40);
                ty = $urandom_range(0, 40);
            end else begin
                tx = $urandom_range(0, 511);
                ty = $urandom_range(0, 511);
            end
            it = write_item($urandom_range(0, ENTRY_COUNT - 1), $urandom_range(0, 6) != 0,
                            tx, ty, pick_width(), pick_width());
        end else if (pick < 80) begin
            // query aimed at one footprint
            k = $urandom_range(0, ENTRY_COUNT - 1);
            footprint_span(fp_tile_x[k], fp_width_x[k], lo_x, hi_x);
            footprint_span(fp_tile_y[k], fp_width_y[k], lo_z, hi_z);
            aimed_range(lo_x, hi_x, qx0, qx1);
            aimed_range(lo_z, hi_z, qz0, qz1);
            case ($urandom_range(0, 19)) inside
                [0:7]:   ign = k;
                [8:12]:  ign = NO_IGNORE;
                [13:15]: ign = $urandom_range(0, ENTRY_COUNT - 1);
                default: ign = int'($signed(SKIP_W'($urandom_range(0, 127))));
            endcase
            it = query_item(qx0, qz0, qx1, qz1, ign);
        end else if (pick < 90) begin
            it = random_payload();
            it.opcode = OP_QUERY;
        end else begin
            // query within the map area
            qx0 = $urandom_range(0, 17000) - 500;
            qz0 = $urandom_range(0, 17000) - 500;
            it = query_item(qx0, qz0, qx0 + $urandom_range(0, 3000) - 200,
                            qz0 + $urandom_range(0, 3000) - 200,
                            $urandom_range(0, ENTRY_COUNT) - 1);
        end
        return it;
    endfunction

    // mostly short gaps, a few long ones, none in a steady stretch
    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one transfer on the input channel; expectation recorded when it is taken
    task automatic send_item(scan_item_t it, bit known, scan_result_t fixed);
        int gap;
        scan_result_t want;
        gap = pick_gap(steady_sender);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= it.opcode;
        s_entry_index  <= it.entry_index;
        s_entry_on     <= it.entry_on;
        s_tile_x       <= it.tile_x;
        s_tile_y       <= it.tile_y;
        s_width_x      <= it.width_x;
        s_width_y      <= it.width_y;
        s_query_min_x  <= it.query_min_x;
        s_query_min_z  <= it.query_min_z;
        s_query_max_x  <= it.query_max_x;
        s_query_max_z  <= it.query_max_z;
        s_ignore_index <= it.ignore_index;
        do @(posedge aclk); while (s_ready !== 1'b1);
        want = scan_footprints(it);
        if (known)
            want = fixed;
        pending_results.push_back(want);
    endtask

    task automatic check_result();
        scan_result_t want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result transfer, hit %0d index %0d ignored %0d",
                     $time, m_hit, m_hit_index, m_ignored_seen);
            mismatches++;
            return;
        end
        want = pending_results.pop_front();
        if (m_hit !== want.hit) begin
            $display("%0t: hit expected %0d got %0d", $time, want.hit, m_hit);
            mismatches++;
        end
        if (m_hit_index !== want.hit_index) begin
            $display("%0t: hit_index expected %0d got %0d", $time, want.hit_index, m_hit_index);
            mismatches++;
        end
        if (m_ignored_seen !== want.ignored_seen) begin
            $display("%0t: ignored_seen expected %0d got %0d", $time, want.ignored_seen,
                     m_ignored_seen);
            mismatches++;
        end
    endtask

    // result side: check each transfer, then choose the next ready level
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1)
                check_result();
            if ($urandom_range(0, 199) == 0)
                steady_receiver = !steady_receiver;
            if (stall_left == 0)
                stall_left = pick_gap(steady_receiver);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid === 1'b1 && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // stimulus: reset, directed table, random items, drain
    initial begin
        scan_item_t it;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_opcode       <= OP_WRITE;
        s_entry_index  <= '0;
        s_entry_on     <= 1'b0;
        s_tile_x       <= '0;
        s_tile_y       <= '0;
        s_width_x      <= '0;
        s_width_y      <= '0;
        s_query_min_x  <= '0;
        s_query_min_z  <= '0;
        s_query_max_x  <= '0;
        s_query_max_z  <= '0;
        s_ignore_index <= '0;
        for (int k = 0; k < ENTRY_COUNT; k++) begin
            fp_on[k]      = 1'b0;
            fp_tile_x[k]  = '0;
            fp_tile_y[k]  = '0;
            fp_width_x[k] = '0;
            fp_width_y[k] = '0;
        end

        // empty table after reset: nothing can overlap
        add_row(query_item(Q_LOWEST, Q_LOWEST, Q_HIGHEST, Q_HIGHEST, NO_IGNORE), 1'b1);
        add_row(query_item(Q_LOWEST, Q_LOWEST, Q_HIGHEST, Q_HIGHEST, 63), 1'b1);
        // writes return all zeros: corners, widest, zero width, widest legal
        add_row(write_item(0, 1'b1, 0, 0, 1, 1), 1'b1);
        add_row(write_item(63, 1'b1, 511, 511, 31, 31), 1'b1);
        add_row(write_item(5, 1'b1, 100, 200, 0, 0), 1'b1);
        add_row(write_item(6, 1'b1, 300, 300, 16, 16), 1'b1);
        add_row(write_item(7, 1'b1, 0, 511, 16, 1), 1'b1);
        // whole plane, then with the first entry ignored
        add_row(query_item(Q_LOWEST, Q_LOWEST, Q_HIGHEST, Q_HIGHEST, NO_IGNORE), 1'b0);
        add_row(query_item(Q_LOWEST, Q_LOWEST, Q_HIGHEST, Q_HIGHEST, 0), 1'b0);
        // exact box edges, one unit inside and outside
        add_row(query_item(31, 31, 31, 31, NO_IGNORE), 1'b0);
        add_row(query_item(32, 32, 32, 32, NO_IGNORE), 1'b0);
        add_row(query_item(-256, 16352, -256, 16352, NO_IGNORE), 1'b0);
        add_row(query_item(-257, 16352, -257, 16352, NO_IGNORE), 1'b0);
        // inverted box
        add_row(query_item(100, Q_LOWEST, 0, Q_HIGHEST, NO_IGNORE), 1'b0);
        // top corner of the last entry, ignored
        add_row(query_item(16863, 16863, Q_HIGHEST, Q_HIGHEST, 63), 1'b0);
        // zero-width footprint, queried on its degenerate span
        add_row(query_item(3200, 6400, 3199, 6399, NO_IGNORE), 1'b0);
        // negative ignore indexes other than none match nothing
        add_row(query_item(Q_LOWEST, Q_LOWEST, Q_HIGHEST, Q_HIGHEST, -64), 1'b0);
        add_row(query_item(Q_LOWEST, Q_LOWEST, Q_HIGHEST, Q_HIGHEST, -2), 1'b0);
        // entry removed, ignore skips to the next overlap
        add_row(write_item(0, 1'b0, 0, 0, 1, 1), 1'b1);
        add_row(query_item(Q_LOWEST, Q_LOWEST, Q_HIGHEST, Q_HIGHEST, 5), 1'b0);
        // single points at the extremes of the query range
        add_row(query_item(Q_LOWEST, Q_LOWEST, Q_LOWEST, Q_LOWEST, NO_IGNORE), 1'b0);
        add_row(query_item(Q_HIGHEST, Q_HIGHEST, Q_HIGHEST, Q_HIGHEST, NO_IGNORE), 1'b0);
        add_row(write_item(6, 1'b1, 511, 0, 31, 0), 1'b1);
        add_row(query_item(Q_LOWEST, Q_LOWEST, Q_HIGHEST, Q_HIGHEST, 6), 1'b0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].result);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 29) == 0)
                steady_sender = !steady_sender;
            it = random_item();
            send_item(it, 1'b0, '0);
            // hold off until the block has delivered everything
            if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) begin
                s_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
